/* src/eidrn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package eidrn_pkg;

  // Default sizing
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int DEGREE_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int ORIG_W   = 64;
  localparam int IDX_W    = 10;
  localparam int OUT_ID_W = 10;
  localparam int OUT_DEG_W = 32;
  localparam int LIMIT_W  = 11;
  localparam int STAT_W   = 2;
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 152;

  // Register indexes
  localparam logic REG_KEEP  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  // Request kinds
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_LIMIT = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;
    logic load;
    logic p_start_t;
    logic p_next;
    logic rec_s;
    logic rec_t;
    logic decide;
    logic ins_s;
    logic ins_t;
    logic bump_wr;
    logic out_load;
  } eidrn_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic in_read;
    logic keep;
    logic hit;
    logic empty;
    logic dec_ok;
    logic s_new;
    logic t_new;
    logic out_free;
  } eidrn_sts_t;

endpackage
`default_nettype wire

/* src/eidrn_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module eidrn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* src/eidrn_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module eidrn_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire eidrn_pkg::eidrn_sts_t sts,
  output eidrn_pkg::eidrn_cmd_t     cmd,
  output logic                      in_ready
);
  import eidrn_pkg::*;

  typedef enum logic [15:0] {
    S_CLR  = 16'h0001,
    S_IDLE = 16'h0002,
    S_RD   = 16'h0004,
    S_RDW  = 16'h0008,
    S_PS   = 16'h0010,
    S_PSC  = 16'h0020,
    S_PT   = 16'h0040,
    S_PTC  = 16'h0080,
    S_DEC  = 16'h0100,
    S_INSS = 16'h0200,
    S_PT2  = 16'h0400,
    S_PT2C = 16'h0800,
    S_INST = 16'h1000,
    S_BR   = 16'h2000,
    S_BW   = 16'h4000,
    S_OUT  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.in_read) state_nxt = S_RD;
          else if (sts.keep) state_nxt = S_DEC;
          else state_nxt = S_PS;
        end
      end
      S_RD: state_nxt = S_RDW;
      S_RDW: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_PS: state_nxt = S_PSC;
      S_PSC: begin
        if (sts.hit || sts.empty) begin
          cmd.rec_s     = 1'b1;
          cmd.p_start_t = 1'b1;
          state_nxt     = S_PT;
        end else begin
          cmd.p_next = 1'b1;
          state_nxt  = S_PS;
        end
      end
      S_PT: state_nxt = S_PTC;
      S_PTC: begin
        if (sts.hit || sts.empty) begin
          cmd.rec_t = 1'b1;
          state_nxt = S_DEC;
        end else begin
          cmd.p_next = 1'b1;
          state_nxt  = S_PT;
        end
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        if (!sts.dec_ok) state_nxt = S_OUT;
        else if (sts.keep) state_nxt = S_BR;
        else if (sts.s_new) state_nxt = S_INSS;
        else if (sts.t_new) state_nxt = S_INST;
        else state_nxt = S_BR;
      end
      S_INSS: begin
        cmd.ins_s = 1'b1;
        if (sts.t_new) begin
          // target slot may have been taken; probe again
          cmd.p_start_t = 1'b1;
          state_nxt     = S_PT2;
        end else begin
          state_nxt = S_BR;
        end
      end
      S_PT2: state_nxt = S_PT2C;
      S_PT2C: begin
        if (sts.hit || sts.empty) begin
          cmd.rec_t = 1'b1;
          state_nxt = S_INST;
        end else begin
          cmd.p_next = 1'b1;
          state_nxt  = S_PT2;
        end
      end
      S_INST: begin
        cmd.ins_t = 1'b1;
        state_nxt = S_BR;
      end
      S_BR: state_nxt = S_BW;
      S_BW: begin
        cmd.bump_wr = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

endmodule
`default_nettype wire

/* src/eidrn_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module eidrn_dp #(
  parameter int MAX_VERTICES = eidrn_pkg::MAX_VERTICES_DEF,
  parameter int DEGREE_WIDTH = eidrn_pkg::DEGREE_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire eidrn_pkg::eidrn_cmd_t                 cmd,
  output eidrn_pkg::eidrn_sts_t                      sts,
  input  wire logic [eidrn_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire logic                                  in_tuser,
  input  wire logic                                  keep,
  input  wire logic [eidrn_pkg::LIMIT_W-1:0]         vlimit,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [eidrn_pkg::OUT_TDATA_W-1:0]          out_tdata
);
  import eidrn_pkg::*;

  localparam int IDW = $clog2(MAX_VERTICES);
  localparam int HW  = IDW + 1;
  localparam int TBL = 2 * MAX_VERTICES;
  localparam int CW  = (IDW + 1 > LIMIT_W) ? IDW + 1 : LIMIT_W;
  localparam int SW  = 1 + IDW + ORIG_W;
  localparam int DW  = DEGREE_WIDTH;

  // Captured item
  logic              req_r;
  logic [ORIG_W-1:0] src_r, tgt_r;
  logic [IDX_W-1:0]  idx_r;

  // Probe and lookup results
  logic [HW-1:0]     paddr_r;
  logic              psel_t_r;
  logic              s_found_r, t_found_r;
  logic [IDW-1:0]    s_id_r, t_id_r;
  logic [HW-1:0]     s_slot_r, t_slot_r;
  logic [STAT_W-1:0] status_r;
  logic [CW-1:0]     next_id_r;
  logic [HW-1:0]     clr_cnt_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Memory ports
  logic [SW-1:0]     slot_q, slot_wdata;
  logic              slot_we;
  logic [HW-1:0]     slot_waddr;
  logic [ORIG_W-1:0] rev_q, rev_wdata;
  logic              rev_we;
  logic [DW-1:0]     in_q, out_q, in_wdata, out_wdata;
  logic              cnt_we;
  logic [IDW-1:0]    in_waddr, out_waddr, in_raddr, out_raddr;

  logic              q_valid;
  logic [IDW-1:0]    q_id;
  logic [ORIG_W-1:0] q_key;
  assign {q_valid, q_id, q_key} = slot_q;

  // Effective limit, clamped to the store size
  logic [CW-1:0] lim;
  assign lim = (CW'(vlimit) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vlimit);

  // Hash start address: xor fold of the key, folded once more into the table
  logic [ORIG_W-1:0] h_key;
  logic [HW-1:0]     h_raw, h_start;
  always_comb begin
    h_key = cmd.load ? in_tdata[ORIG_W-1:0] : tgt_r;
    h_raw = '0;
    for (int i = 0; i < ORIG_W; i++) begin
      h_raw[i % HW] = h_raw[i % HW] ^ h_key[i];
    end
    h_start = ({1'b0, h_raw} >= (HW+1)'(TBL)) ? HW'({1'b0, h_raw} - (HW+1)'(TBL)) : h_raw;
  end

  logic eq, hit;
  assign eq  = (src_r == tgt_r);
  assign hit = q_valid && (q_key == (psel_t_r ? tgt_r : src_r));

  // Edge decision
  logic [STAT_W-1:0] dec_status;
  logic              range_k, st1, st2;
  logic [1:0]        need;
  always_comb begin
    range_k = (src_r >= ORIG_W'(lim)) || (tgt_r >= ORIG_W'(lim));
    st1 = (s_found_r && (CW'(s_id_r) >= lim)) || (t_found_r && (CW'(t_id_r) >= lim));
    need = {1'b0, !s_found_r} + {1'b0, (!t_found_r && !eq)};
    st2 = ({1'b0, next_id_r} + (CW+1)'(need)) > {1'b0, lim};
    if (keep) dec_status = range_k ? ST_RANGE : ST_OK;
    else if (st1) dec_status = ST_RANGE;
    else if (st2) dec_status = ST_LIMIT;
    else dec_status = ST_OK;
  end

  // Control and payload registers
  logic clr_last;
  assign clr_last = (clr_cnt_r == HW'(TBL - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr && !clr_last) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.ins_s || cmd.ins_t) next_id_r <= next_id_r + 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Read result fields
  logic [CW-1:0]        idx_c;
  logic                 rd_bad;
  logic [ORIG_W-1:0]    rd_orig;
  logic [DW+31:0]       in_x, out_x;
  logic [IDW+9:0]       s_x, t_x;
  logic [OUT_TDATA_W-1:0] res;
  always_comb begin
    idx_c   = CW'(idx_r);
    rd_bad  = idx_c >= CW'(MAX_VERTICES);
    rd_orig = keep ? ORIG_W'(idx_r) : ((idx_c < next_id_r) ? rev_q : '0);
    in_x    = {32'b0, in_q};
    out_x   = {32'b0, out_q};
    s_x     = {10'b0, s_id_r};
    t_x     = {10'b0, t_id_r};
    if (req_r == REQ_READ) begin
      if (rd_bad) res = {2'b0, 64'b0, 32'b0, 32'b0, ST_RANGE, 20'b0};
      else res = {2'b0, rd_orig, out_x[31:0], in_x[31:0], ST_OK, 20'b0};
    end else if (status_r == ST_OK) begin
      res = {2'b0, 64'b0, 32'b0, 32'b0, ST_OK, t_x[9:0], s_x[9:0]};
    end else begin
      res = {2'b0, 64'b0, 32'b0, 32'b0, status_r, 20'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_tuser;
      src_r    <= in_tdata[63:0];
      tgt_r    <= in_tdata[127:64];
      idx_r    <= in_tdata[137:128];
      paddr_r  <= h_start;
      psel_t_r <= 1'b0;
    end else if (cmd.p_start_t) begin
      paddr_r  <= h_start;
      psel_t_r <= 1'b1;
    end else if (cmd.p_next) begin
      paddr_r <= (paddr_r == HW'(TBL - 1)) ? '0 : paddr_r + 1'b1;
    end
    if (cmd.rec_s) begin
      s_found_r <= hit;
      s_id_r    <= q_id;
      s_slot_r  <= paddr_r;
    end
    if (cmd.rec_t) begin
      t_found_r <= hit;
      t_id_r    <= q_id;
      t_slot_r  <= paddr_r;
    end
    if (cmd.decide) begin
      status_r <= dec_status;
      if (keep) begin
        s_id_r <= src_r[IDW-1:0];
        t_id_r <= tgt_r[IDW-1:0];
      end
    end
    if (cmd.ins_s) begin
      s_id_r <= next_id_r[IDW-1:0];
      if (eq) t_id_r <= next_id_r[IDW-1:0];
    end
    if (cmd.ins_t) t_id_r <= next_id_r[IDW-1:0];
    if (cmd.out_load) out_data_r <= res;
  end

  // Memory write ports
  always_comb begin
    slot_we    = cmd.clr || cmd.ins_s || cmd.ins_t;
    slot_waddr = cmd.clr ? clr_cnt_r : (cmd.ins_s ? s_slot_r : t_slot_r);
    slot_wdata = cmd.clr ? '0 :
                 {1'b1, next_id_r[IDW-1:0], (cmd.ins_s ? src_r : tgt_r)};
    rev_we     = cmd.ins_s || cmd.ins_t;
    rev_wdata  = cmd.ins_s ? src_r : tgt_r;
    cnt_we     = (cmd.clr && ({1'b0, clr_cnt_r} < (HW+1)'(MAX_VERTICES))) || cmd.bump_wr;
    in_waddr   = cmd.clr ? clr_cnt_r[IDW-1:0] : t_id_r;
    out_waddr  = cmd.clr ? clr_cnt_r[IDW-1:0] : s_id_r;
    in_wdata   = cmd.clr ? '0 : ((in_q == {DW{1'b1}}) ? in_q : in_q + 1'b1);
    out_wdata  = cmd.clr ? '0 : ((out_q == {DW{1'b1}}) ? out_q : out_q + 1'b1);
    in_raddr   = (req_r == REQ_READ) ? idx_c[IDW-1:0] : t_id_r;
    out_raddr  = (req_r == REQ_READ) ? idx_c[IDW-1:0] : s_id_r;
  end

  // Hash slots: valid, dense id, key
  eidrn_ram #(.WIDTH(SW), .DEPTH(TBL)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(paddr_r), .rdata(slot_q)
  );

  // Dense id to original id
  eidrn_ram #(.WIDTH(ORIG_W), .DEPTH(MAX_VERTICES)) u_rev (
    .clk(clk), .we(rev_we), .waddr(next_id_r[IDW-1:0]), .wdata(rev_wdata),
    .raddr(idx_c[IDW-1:0]), .rdata(rev_q)
  );

  // Degree counters
  eidrn_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_indeg (
    .clk(clk), .we(cnt_we), .waddr(in_waddr), .wdata(in_wdata),
    .raddr(in_raddr), .rdata(in_q)
  );

  eidrn_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_outdeg (
    .clk(clk), .we(cnt_we), .waddr(out_waddr), .wdata(out_wdata),
    .raddr(out_raddr), .rdata(out_q)
  );

  // Status to the controller
  always_comb begin
    sts.clr_done = clr_last;
    sts.in_read  = (in_tuser == REQ_READ);
    sts.keep     = keep;
    sts.hit      = hit;
    sts.empty    = !q_valid;
    sts.dec_ok   = (dec_status == ST_OK);
    sts.s_new    = !s_found_r;
    sts.t_new    = !t_found_r && !eq;
    sts.out_free = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

/* src/edge_id_renumber_degree_count.sv */
// Sequence: a read item reads the degree counters; an edge in keep-ids mode skips the
//   hash probes; a renumbered edge probes source and target and inserts each new id,
//   re-probing the target after a new source. A flagged edge skips the degree update.
// Throughput: one item at a time; the next is taken the cycle after the result loads.
//   The hash-probe loop on the slot RAM's single read port and the degree read-modify-write
//   limit the rate. Output register frees the input; a stalled result holds up the next.
// Reset: rst_n synchronous, active low; a clearing pass over all 2*MAX_VERTICES hash slots
//   also zeroes the degree counters, and no input is taken until it ends.
`timescale 1ns / 1ps
`default_nettype none
module edge_id_renumber_degree_count #(
  parameter int MAX_VERTICES = eidrn_pkg::MAX_VERTICES_DEF,
  parameter int DEGREE_WIDTH = eidrn_pkg::DEGREE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // src_orig[63:0], tgt_orig[127:64], read_index[137:128], zero pad
  input  wire logic [eidrn_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // src_id[9:0], tgt_id[19:10], status[21:20], in_count[53:22],
  // out_count[85:54], orig_id[149:86], zero pad
  output logic [eidrn_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [2:0]                        cfg_paddr,
  input  wire logic [31:0]                       cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);
  import eidrn_pkg::*;

  logic               keep_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               wr_en;
  eidrn_cmd_t         cmd;
  eidrn_sts_t         sts;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r  <= 1'b0;
      limit_r <= LIMIT_W'(1024);
    end else if (wr_en) begin
      if (cfg_paddr[2] == REG_KEEP) keep_r <= cfg_pwdata[0];
      else limit_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_LIMIT) ? {21'b0, limit_r} : {31'b0, keep_r};

  eidrn_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .sts(sts), .cmd(cmd),
    .in_ready(in_tready)
  );

  eidrn_dp #(.MAX_VERTICES(MAX_VERTICES), .DEGREE_WIDTH(DEGREE_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .keep(keep_r), .vlimit(limit_r), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule
`default_nettype wire

/* src/eidrn_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
module eidrn_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [151:0] out_tdata
);

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Clearing pass keeps input closed in the cycle after reset
  a_clear_closed: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input open during clearing pass");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Status code is in range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[21:20] != 2'd3)
    else $error("bad status code");

  // A flagged result carries no ids, degrees or original id
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21:20] != 2'd0 |-> out_tdata[19:0] == 20'd0 &&
    out_tdata[151:22] == 130'd0)
    else $error("flagged result has payload");

endmodule

bind edge_id_renumber_degree_count eidrn_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
